// ===== src/apsr_pkg.sv =====
// apsr_pkg: shared types, codes and constants of the analog pad serial responder
// used by apsr_ctrl, apsr_dp and analog_pad_serial_responder_unit; no dependencies
package apsr_pkg;

  // item commands, carried on tuser
  localparam logic [1:0] CMD_SERIAL = 2'd0;
  localparam logic [1:0] CMD_AXIS   = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  // configuration register indexes
  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_CURVE    = 1'b1;

  // steering curve codes, the unused code acts as linear
  localparam logic [1:0] CURVE_LIN  = 2'd0;
  localparam logic [1:0] CURVE_QUAD = 2'd1;
  localparam logic [1:0] CURVE_CUBE = 2'd2;

  localparam logic [1:0] AXIS_STEER = 2'd0;

  localparam logic [15:0] DEADZONE_RST = 16'd6554;
  localparam logic [15:0] PAD_ID       = 16'h5A23;
  localparam logic [7:0]  BYTE_START   = 8'h01;
  localparam logic [7:0]  BYTE_POLL    = 8'h42;
  localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
  localparam logic [7:0]  STEER_RST    = 8'h80;
  localparam logic [15:0] BUTTONS_RST  = 16'hFFFF;

  // divider: one integer quotient bit plus sixteen fraction bits
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    SEQ_IDLE     = 4'd0,
    SEQ_READY    = 4'd1,
    SEQ_ID_HIGH  = 4'd2,
    SEQ_BTN_LOW  = 4'd3,
    SEQ_BTN_HIGH = 4'd4,
    SEQ_STEER    = 4'd5,
    SEQ_AX_I     = 4'd6,
    SEQ_AX_II    = 4'd7,
    SEQ_AX_L     = 4'd8
  } seq_e;

  typedef enum logic [2:0] {
    C_IDLE = 3'd0,
    C_DIV  = 3'd1,
    C_SQ   = 3'd2,
    C_CUBE = 3'd3,
    C_EXEC = 3'd4
  } ctrl_e;

  typedef struct packed {
    logic capture;
    logic div_first;
    logic div_step;
    logic mul_sq;
    logic mul_cube;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic steer_req;
    logic out_busy;
  } sts_t;

  // button number to bit of the button word
  function automatic logic [3:0] btn_bit(input logic [2:0] idx);
    logic [3:0] b;
    b = 4'd3;
    unique case (idx)
      3'd0: b = 4'd3;
      3'd1: b = 4'd4;
      3'd2: b = 4'd5;
      3'd3: b = 4'd6;
      3'd4: b = 4'd7;
      3'd5: b = 4'd11;
      3'd6: b = 4'd12;
      3'd7: b = 4'd13;
      default: b = 4'd3;
    endcase
    return b;
  endfunction

endpackage

// ===== src/analog_pad_serial_responder_unit.sv =====
// Analog pad that answers a host serial poll, one result transfer per input transfer.
// Serial, button, reset and plain axis items go from capture straight to commit, which registers
// the result; a steering update goes from capture through the 17-step restoring deadzone
// divider and two passes through the shared curve multiplier before commit. Commit waits
// while the previous result is still unclaimed.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken. Configuration writes take effect at the next clock edge.
module analog_pad_serial_responder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // serial_in[7:0], axis_index[9:8], axis_value[25:10], button_index[28:26],
  // pressed[29], zero fill
  input  logic [31:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // serial_out[7:0], ack[8], pressed_bits[24:9], analog_word[56:25], zero fill
  output logic [63:0] m_axis_tdata
);

  apsr_pkg::ctl_t ctl;
  apsr_pkg::sts_t sts;
  logic [7:0]  serial_out;
  logic        ack;
  logic [15:0] pressed_bits;
  logic [31:0] analog_word;

  apsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  apsr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (s_axis_tuser),
    .serial_in_i    (s_axis_tdata[7:0]),
    .axis_index_i   (s_axis_tdata[9:8]),
    .axis_value_i   (s_axis_tdata[25:10]),
    .button_index_i (s_axis_tdata[28:26]),
    .pressed_i      (s_axis_tdata[29]),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .serial_out_o   (serial_out),
    .ack_o          (ack),
    .pressed_bits_o (pressed_bits),
    .analog_word_o  (analog_word)
  );

  assign m_axis_tdata = {7'd0, analog_word, pressed_bits, ack, serial_out};

`ifndef SYNTHESIS
  // a result is only committed into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |-> !sts.out_busy)
    else $error("commit while output register is blocked");

  // every commit shows up as a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // no new item is taken while the divider or multiplier is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.div_first || ctl.div_step || ctl.mul_sq || ctl.mul_cube) |-> !s_axis_tready)
    else $error("input ready during steering computation");

  // capture and commit never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.capture && ctl.commit))
    else $error("capture and commit in the same cycle");
`endif

endmodule

// ===== src/apsr_ctrl.sv =====
// apsr_ctrl: controller state machine, sequences capture, division, curve products and commit
// depends on apsr_pkg
module apsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  apsr_pkg::sts_t   sts_i,
  output apsr_pkg::ctl_t   ctl_o
);

  apsr_pkg::ctrl_e state_q, state_d;
  logic [apsr_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apsr_pkg::C_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      apsr_pkg::C_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = sts_i.steer_req ? apsr_pkg::C_DIV : apsr_pkg::C_EXEC;
        end
      end
      apsr_pkg::C_DIV: begin
        ctl_o.div_first = (cnt_q == '0);
        ctl_o.div_step  = (cnt_q != '0);
        if (cnt_q == apsr_pkg::CNT_W'(apsr_pkg::DIV_STEPS - 1)) begin
          state_d = apsr_pkg::C_SQ;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      apsr_pkg::C_SQ: begin
        ctl_o.mul_sq = 1'b1;
        state_d      = apsr_pkg::C_CUBE;
      end
      apsr_pkg::C_CUBE: begin
        ctl_o.mul_cube = 1'b1;
        state_d        = apsr_pkg::C_EXEC;
      end
      apsr_pkg::C_EXEC: begin
        // wait here while the previous result is still unclaimed
        if (!sts_i.out_busy) begin
          ctl_o.commit = 1'b1;
          state_d      = apsr_pkg::C_IDLE;
        end
      end
      default: state_d = apsr_pkg::C_IDLE;
    endcase
  end

endmodule

// ===== src/apsr_dp.sv =====
// apsr_dp: datapath with pad state, reply sequencer, steering divider and multiplier,
// and the result register; depends on apsr_pkg
module apsr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         command_i,
  input  logic [7:0]         serial_in_i,
  input  logic [1:0]         axis_index_i,
  input  logic signed [15:0] axis_value_i,
  input  logic [2:0]         button_index_i,
  input  logic               pressed_i,
  input  apsr_pkg::ctl_t     ctl_i,
  output apsr_pkg::sts_t     sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         serial_out_o,
  output logic               ack_o,
  output logic [15:0]        pressed_bits_o,
  output logic [31:0]        analog_word_o
);

  // configuration
  logic [15:0] dz_q;
  logic [1:0]  curve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= apsr_pkg::DEADZONE_RST;
      curve_q <= apsr_pkg::CURVE_LIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        apsr_pkg::REG_DEADZONE: dz_q    <= cfg_data_i;
        apsr_pkg::REG_CURVE:    curve_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]         cmd_q;
  logic [7:0]         din_q;
  logic [1:0]         axis_q;
  logic signed [15:0] val_q;
  logic [2:0]         btn_q;
  logic               prs_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= command_i;
      din_q  <= serial_in_i;
      axis_q <= axis_index_i;
      val_q  <= axis_value_i;
      btn_q  <= button_index_i;
      prs_q  <= pressed_i;
    end
  end

  assign sts_o.steer_req = (command_i == apsr_pkg::CMD_AXIS) &&
                           (axis_index_i == apsr_pkg::AXIS_STEER);

  // steering deadzone removal and rescale: f = (a - dz) * 2^16 / (2^16 - dz)
  logic        neg;
  logic [15:0] mag;
  logic [16:0] a_full, dz_ext, num, den;
  logic [17:0] rem_q, rem_d, rem_sh;
  logic [16:0] q_q, q_d;
  logic        ge;

  assign neg    = val_q[15];
  assign mag    = neg ? (~val_q + 16'd1) : val_q;
  assign a_full = {mag, 1'b0};
  assign dz_ext = {1'b0, dz_q};
  assign num    = (a_full >= dz_ext) ? (a_full - dz_ext) : 17'd0;
  assign den    = 17'h10000 - dz_ext;
  assign rem_sh = {rem_q[16:0], 1'b0};

  always_comb begin
    rem_d = rem_q;
    q_d   = q_q;
    ge    = 1'b0;
    if (ctl_i.div_first) begin
      // integer bit: set only when the numerator is at least the divisor
      ge    = (num >= den);
      rem_d = ge ? {1'b0, num - den} : {1'b0, num};
      q_d   = {16'd0, ge};
    end else if (ctl_i.div_step) begin
      ge    = (rem_sh >= {1'b0, den});
      rem_d = ge ? (rem_sh - {1'b0, den}) : rem_sh;
      q_d   = {q_q[15:0], ge};
    end
  end

  // curve products through one shared multiplier
  logic [31:0] mul_a;
  logic [47:0] prod;
  logic [31:0] sq_q;
  logic [15:0] cube_q;

  assign mul_a = ctl_i.mul_cube ? sq_q : {16'd0, q_q[15:0]};
  assign prod  = mul_a * q_q[15:0];

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    if (ctl_i.mul_sq) begin
      sq_q <= prod[31:0];
    end
    if (ctl_i.mul_cube) begin
      cube_q <= prod[47:32];
    end
  end

  // curve, sign and rounding to 0..255
  logic [16:0] m;
  logic [17:0] sp;
  logic [25:0] w;
  logic [8:0]  b9;
  logic [7:0]  steer_byte, plain_byte;
  logic [22:0] pl;

  always_comb begin
    if (q_q[16]) begin
      m = 17'h10000;
    end else begin
      case (curve_q)
        apsr_pkg::CURVE_QUAD: m = {1'b0, sq_q[31:16]};
        apsr_pkg::CURVE_CUBE: m = {1'b0, cube_q};
        default:              m = q_q;
      endcase
    end
  end

  assign sp = neg ? (18'h10000 - {1'b0, m}) : (18'h10000 + {1'b0, m});
  assign w  = {sp, 8'd0} - {8'd0, sp} + 26'h10000;
  assign b9 = w[25:17];
  assign steer_byte = b9[8] ? 8'hFF : b9[7:0];

  assign pl = {val_q[14:0], 8'd0} - {8'd0, val_q[14:0]};
  assign plain_byte = neg ? 8'd0 : pl[22:15];

  // pad state
  apsr_pkg::seq_e seq_q, seq_d;
  logic [15:0] btn_word_q, btn_word_d, btn_mask;
  logic [7:0]  axis_q_arr [4];
  logic [7:0]  axis_d_arr [4];
  logic [7:0]  dout;
  logic        ack;

  assign btn_mask = 16'd1 << apsr_pkg::btn_bit(btn_q);

  always_comb begin
    seq_d      = seq_q;
    btn_word_d = btn_word_q;
    for (int i = 0; i < 4; i++) begin
      axis_d_arr[i] = axis_q_arr[i];
    end
    dout = apsr_pkg::BYTE_IDLE;
    ack  = 1'b0;
    unique case (cmd_q)
      apsr_pkg::CMD_SERIAL: begin
        unique case (seq_q)
          apsr_pkg::SEQ_IDLE: begin
            if (din_q == apsr_pkg::BYTE_START) begin
              seq_d = apsr_pkg::SEQ_READY;
              ack   = 1'b1;
            end
          end
          apsr_pkg::SEQ_READY: begin
            if (din_q == apsr_pkg::BYTE_POLL) begin
              dout  = apsr_pkg::PAD_ID[7:0];
              seq_d = apsr_pkg::SEQ_ID_HIGH;
              ack   = 1'b1;
            end
          end
          apsr_pkg::SEQ_ID_HIGH: begin
            dout  = apsr_pkg::PAD_ID[15:8];
            seq_d = apsr_pkg::SEQ_BTN_LOW;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_BTN_LOW: begin
            dout  = btn_word_q[7:0];
            seq_d = apsr_pkg::SEQ_BTN_HIGH;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_BTN_HIGH: begin
            dout  = btn_word_q[15:8];
            seq_d = apsr_pkg::SEQ_STEER;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_STEER: begin
            dout  = axis_q_arr[0];
            seq_d = apsr_pkg::SEQ_AX_I;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_AX_I: begin
            dout  = axis_q_arr[1];
            seq_d = apsr_pkg::SEQ_AX_II;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_AX_II: begin
            dout  = axis_q_arr[2];
            seq_d = apsr_pkg::SEQ_AX_L;
            ack   = 1'b1;
          end
          apsr_pkg::SEQ_AX_L: begin
            // last reply byte goes out without ack
            dout  = axis_q_arr[3];
            seq_d = apsr_pkg::SEQ_IDLE;
          end
          default: seq_d = apsr_pkg::SEQ_IDLE;
        endcase
      end
      apsr_pkg::CMD_AXIS: begin
        axis_d_arr[axis_q] = (axis_q == apsr_pkg::AXIS_STEER) ? steer_byte : plain_byte;
      end
      apsr_pkg::CMD_BUTTON: begin
        btn_word_d = prs_q ? (btn_word_q & ~btn_mask) : (btn_word_q | btn_mask);
      end
      apsr_pkg::CMD_RESET: seq_d = apsr_pkg::SEQ_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= apsr_pkg::SEQ_IDLE;
      btn_word_q    <= apsr_pkg::BUTTONS_RST;
      axis_q_arr[0] <= apsr_pkg::STEER_RST;
      axis_q_arr[1] <= 8'd0;
      axis_q_arr[2] <= 8'd0;
      axis_q_arr[3] <= 8'd0;
    end else if (ctl_i.commit) begin
      seq_q      <= seq_d;
      btn_word_q <= btn_word_d;
      for (int i = 0; i < 4; i++) begin
        axis_q_arr[i] <= axis_d_arr[i];
      end
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      serial_out_o   <= dout;
      ack_o          <= ack;
      pressed_bits_o <= ~btn_word_d;
      analog_word_o  <= {axis_d_arr[3], axis_d_arr[2], axis_d_arr[1], axis_d_arr[0]};
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule
